// File: rtl/core/cswr_pkg.sv
package cswr_pkg;

	// Field widths of one beat on each channel
	localparam int OBJ_W  = 32;
	localparam int PAGE_W = 31;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 32;

	// Per-slot storage widths
	localparam int TAG_W  = OBJ_W + PAGE_W;
	localparam int USE_W  = 8;

	// Slot address as carried between modules; wide enough for the largest pool
	localparam int ADDR_W = 8;

	// Request codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [OBJ_W-1:0]  object_id;
		logic [PAGE_W-1:0] page_no;
		logic [SLOT_W-1:0] release_slot;
	} cswr_in_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              no_victim;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  read_count;
	} cswr_out_t;

	// Sequencer to slot store
	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] wr_addr;
		logic              tag_we;
		logic              use_we;
		logic              valid_set;
		logic [TAG_W-1:0]  wr_tag;
		logic [USE_W-1:0]  wr_use;
		logic              pin_set;
		logic              pin_clr;
		logic [ADDR_W-1:0] pin_addr;
	} store_ctl_t;

	// Slot store to sequencer, for the slot read in the previous cycle
	typedef struct packed {
		logic [TAG_W-1:0] rd_tag;
		logic [USE_W-1:0] rd_use;
		logic             rd_valid;
		logic             rd_pinned;
		logic             all_pinned;
	} store_sts_t;

endpackage

// File: rtl/core/cswr_slot_store.sv
module cswr_slot_store import cswr_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_ctl_t ctl,
	output store_sts_t sts
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int PCW   = $clog2(NUM_SLOTS + 1);

	logic [TAG_W-1:0]     tag_mem [NUM_SLOTS];
	logic [USE_W-1:0]     use_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] pin_q;
	logic [PCW-1:0]       pin_cnt_q;
	logic [TAG_W-1:0]     rd_tag_q;
	logic [USE_W-1:0]     rd_use_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic [IDX_W-1:0]     rd_idx;
	logic [IDX_W-1:0]     wr_idx;
	logic [IDX_W-1:0]     pin_idx;

	assign rd_idx  = ctl.rd_addr[IDX_W-1:0];
	assign wr_idx  = ctl.wr_addr[IDX_W-1:0];
	assign pin_idx = ctl.pin_addr[IDX_W-1:0];

	// Tag and usage memories: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[wr_idx] <= ctl.wr_tag;
		end
		if (ctl.use_we) begin
			use_mem[wr_idx] <= ctl.wr_use;
		end
		rd_tag_q <= tag_mem[rd_idx];
		rd_use_q <= use_mem[rd_idx];
	end

	// Valid and pin bits, with a running count of pinned slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			pin_q     <= '0;
			pin_cnt_q <= '0;
			rd_addr_q <= '0;
		end else begin
			rd_addr_q <= rd_idx;
			if (ctl.valid_set) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.pin_set && !pin_q[pin_idx]) begin
				pin_q[pin_idx] <= 1'b1;
				pin_cnt_q      <= pin_cnt_q + PCW'(1);
			end else if (ctl.pin_clr && pin_q[pin_idx]) begin
				pin_q[pin_idx] <= 1'b0;
				pin_cnt_q      <= pin_cnt_q - PCW'(1);
			end
		end
	end

	// An empty slot reads as usage zero
	always_comb begin
		sts.rd_tag     = rd_tag_q;
		sts.rd_valid   = valid_q[rd_addr_q];
		sts.rd_use     = valid_q[rd_addr_q] ? rd_use_q : '0;
		sts.rd_pinned  = pin_q[rd_addr_q];
		sts.all_pinned = (pin_cnt_q == PCW'(NUM_SLOTS));
	end

	a_pin_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pin_cnt_q <= PCW'(NUM_SLOTS))
		else $error("pinned slot count above pool size");

	a_pin_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pin_q) == int'(pin_cnt_q))
		else $error("pinned slot count out of step with pin bits");

	a_install_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tag_we |-> (ctl.use_we && ctl.valid_set && ctl.pin_set))
		else $error("slot install without usage, valid and pin update");

endmodule

// File: rtl/core/clock_sweep_buffer_replacement_core.sv
// Buffer-pool slot manager with clock-sweep replacement and usage counts.
// Input channel (in_valid/in_ready/in_data): one beat is a request for a
// page (object_id, page_no) or a release of release_slot's pin.
// Output channel (out_valid/out_ready/out_data): one result beat per input
// beat, in order: slot, hit, no_victim and the running hit and read totals.
// One item is worked at a time; in_ready is high only while the sequencer
// is idle. Each slot visit uses the single read port of the
// tag and usage memories (address, then registered data and compare).
// Slots visited from accept to result register, N = NUM_SLOTS:
//   release: none, straight to the final state
//   hit in slot k: lookup visits slots 0 to k
//   miss: lookup visits all N, then the hand visits S slots (at least 1)
//   miss with every slot pinned: lookup visits all N, no sweep
// A new item is taken as soon as the result sits in the output register,
// so a stalled receiver holds at most one finished result; the sequencer
// waits in its final state only while that register is still full.
// Reset empties every slot (an empty slot reads as usage zero), clears pins,
// the hand and both totals; no clearing pass is needed and an item is accepted right after reset.
module clock_sweep_buffer_replacement_core import cswr_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cswr_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output cswr_out_t out_data
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int RNG_W = ADDR_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK_RD,
		ST_LOOK_CMP,
		ST_SWEEP_RD,
		ST_SWEEP_EVAL,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  hand_q;
	logic [TAG_W-1:0]  req_tag_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_hit_q;
	logic              res_nv_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [CNT_W-1:0]  read_cnt_q;
	logic              out_valid_q;
	cswr_out_t         out_q;

	store_ctl_t        ctl;
	store_sts_t        sts;

	logic              accept;
	logic              rel_in_range;
	logic              look_hit;
	logic              sweep_take;
	logic [USE_W-1:0]  use_inc;
	logic [IDX_W-1:0]  hand_nxt;
	logic              out_free;

	cswr_slot_store #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sts   (sts)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Shared compare unit: release range check, tag match, zero usage, saturating step, hand wrap
	assign rel_in_range = (RNG_W'(in_data.release_slot) < RNG_W'(NUM_SLOTS));
	assign look_hit     = sts.rd_valid && (sts.rd_tag == req_tag_q);
	assign sweep_take   = !sts.rd_pinned && (sts.rd_use == '0);
	assign use_inc      = (sts.rd_use == '1) ? sts.rd_use : sts.rd_use + USE_W'(1);
	assign hand_nxt     = (hand_q == LAST) ? '0 : hand_q + IDX_W'(1);

	// Drive the slot store from the current step
	always_comb begin
		ctl           = '0;
		ctl.wr_tag    = req_tag_q;
		ctl.rd_addr   = (state_q == ST_SWEEP_RD) ? ADDR_W'(hand_q) : ADDR_W'(idx_q);
		ctl.wr_addr   = (state_q == ST_SWEEP_EVAL) ? ADDR_W'(hand_q) : ADDR_W'(idx_q);
		ctl.pin_addr  = ctl.wr_addr;
		unique case (state_q) inside
			ST_IDLE: begin
				if (accept && in_data.opcode == OP_RELEASE && rel_in_range) begin
					ctl.pin_clr  = 1'b1;
					ctl.pin_addr = ADDR_W'(in_data.release_slot);
				end
			end
			ST_LOOK_CMP: begin
				if (look_hit) begin
					ctl.use_we  = 1'b1;
					ctl.wr_use  = use_inc;
					ctl.pin_set = 1'b1;
				end
			end
			ST_SWEEP_EVAL: begin
				if (sweep_take) begin
					ctl.tag_we    = 1'b1;
					ctl.use_we    = 1'b1;
					ctl.wr_use    = USE_W'(1);
					ctl.valid_set = 1'b1;
					ctl.pin_set   = 1'b1;
				end else if (sts.rd_use != '0) begin
					ctl.use_we = 1'b1;
					ctl.wr_use = sts.rd_use - USE_W'(1);
				end
			end
			ST_LOOK_RD, ST_SWEEP_RD, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			hand_q      <= '0;
			req_tag_q   <= '0;
			res_slot_q  <= '0;
			res_hit_q   <= 1'b0;
			res_nv_q    <= 1'b0;
			hit_cnt_q   <= '0;
			read_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_tag_q  <= {in_data.object_id, in_data.page_no};
						idx_q      <= '0;
						res_hit_q  <= 1'b0;
						res_nv_q   <= 1'b0;
						if (in_data.opcode == OP_RELEASE) begin
							res_slot_q <= in_data.release_slot;
							state_q    <= ST_FIN;
						end else begin
							res_slot_q <= '0;
							state_q    <= ST_LOOK_RD;
						end
					end
				end
				ST_LOOK_RD: begin
					state_q <= ST_LOOK_CMP;
				end
				ST_LOOK_CMP: begin
					if (look_hit) begin
						hit_cnt_q  <= hit_cnt_q + CNT_W'(1);
						res_slot_q <= SLOT_W'(ADDR_W'(idx_q));
						res_hit_q  <= 1'b1;
						state_q    <= ST_FIN;
					end else if (idx_q != LAST) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_LOOK_RD;
					end else if (sts.all_pinned) begin
						res_nv_q <= 1'b1;
						state_q  <= ST_FIN;
					end else begin
						state_q <= ST_SWEEP_RD;
					end
				end
				ST_SWEEP_RD: begin
					state_q <= ST_SWEEP_EVAL;
				end
				ST_SWEEP_EVAL: begin
					// advance the hand past every visited slot
					hand_q <= hand_nxt;
					if (sweep_take) begin
						read_cnt_q <= read_cnt_q + CNT_W'(1);
						res_slot_q <= SLOT_W'(ADDR_W'(hand_q));
						state_q    <= ST_FIN;
					end else begin
						state_q <= ST_SWEEP_RD;
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.slot       <= res_slot_q;
						out_q.hit        <= res_hit_q;
						out_q.no_victim  <= res_nv_q;
						out_q.hit_count  <= hit_cnt_q;
						out_q.read_count <= read_cnt_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= LAST)
		else $error("clock hand beyond last slot");

	a_nv_all_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && res_nv_q) |-> sts.all_pinned)
		else $error("no_victim reported with an unpinned slot");

	a_install_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP_EVAL && sweep_take) |=>
		(read_cnt_q == $past(read_cnt_q) + CNT_W'(1)))
		else $error("slot install without read count step");

endmodule

// File: tb/cswr_result_checker.sv
module cswr_result_checker import cswr_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  cswr_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  cswr_out_t out_data,
	output int        mismatch_count,
	output int        answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int USE_MAX      = (1 << USE_W) - 1;
	// an unpinned slot drains to zero usage within this many passes of the hand
	localparam int SWEEP_ROUNDS = USE_MAX + 2;
	localparam int PRINT_LIMIT  = 40;

	// Shadow copy of the slot table
	logic              resident [NUM_SLOTS];
	logic [OBJ_W-1:0]  tag_obj  [NUM_SLOTS];
	logic [PAGE_W-1:0] tag_page [NUM_SLOTS];
	logic [USE_W-1:0]  usage    [NUM_SLOTS];
	logic              pin      [NUM_SLOTS];
	int unsigned       hand;
	logic [CNT_W-1:0]  hits_seen;
	logic [CNT_W-1:0]  reads_done;

	// Answers owed by the block, oldest first
	cswr_out_t answers_due [$];

	initial begin
		mismatch_count = 0;
		answers_pending = 0;
	end

	// Print one line per mismatch (up to a cap) and count it
	task automatic flag_mismatch(input string note);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $realtime, note);
		mismatch_count++;
	endtask

	// Work out the answer to one request or release and advance the shadow table
	function automatic cswr_out_t predict_slot_answer(input cswr_in_t beat);
		cswr_out_t   answer;
		int          match_at;
		bit          any_free;
		bit          placed;
		int unsigned h;
		answer = '0;
		match_at = -1;
		any_free = 1'b0;
		placed = 1'b0;
		if (beat.opcode == OP_RELEASE) begin
			// out-of-range slots are ignored, empty or unpinned ones just stay unpinned
			if (beat.release_slot < NUM_SLOTS)
				pin[beat.release_slot] = 1'b0;
			answer.slot = beat.release_slot;
		end else begin
			// look up the tag; only resident slots can match
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (match_at < 0 && resident[i] && tag_obj[i] == beat.object_id &&
						tag_page[i] == beat.page_no)
					match_at = i;
			end
			if (match_at >= 0) begin
				if (usage[match_at] != '1)
					usage[match_at]++;
				pin[match_at] = 1'b1;
				hits_seen++;
				answer.slot = SLOT_W'(match_at);
				answer.hit = 1'b1;
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!pin[i])
						any_free = 1'b1;
				end
				if (any_free) begin
					// sweep: take the first unpinned slot at zero usage, age the rest
					if (hand >= NUM_SLOTS)
						hand = 0;
					for (int n = 0; n < NUM_SLOTS * SWEEP_ROUNDS && !placed; n++) begin
						h = hand;
						if (!pin[h] && usage[h] == '0) begin
							resident[h] = 1'b1;
							tag_obj[h] = beat.object_id;
							tag_page[h] = beat.page_no;
							usage[h] = USE_W'(1);
							pin[h] = 1'b1;
							reads_done++;
							answer.slot = SLOT_W'(h);
							placed = 1'b1;
						end else if (usage[h] != '0) begin
							usage[h]--;
						end
						hand = (h + 1) % NUM_SLOTS;
					end
				end
				// every slot pinned: nothing changes
				if (!placed)
					answer.no_victim = 1'b1;
			end
		end
		answer.hit_count = hits_seen;
		answer.read_count = reads_done;
		return answer;
	endfunction

	// Watch both channels: check results first, then queue the new answer
	always @(posedge clk) begin
		cswr_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				resident[i] = 1'b0;
				tag_obj[i] = '0;
				tag_page[i] = '0;
				usage[i] = '0;
				pin[i] = 1'b0;
			end
			hand = 0;
			hits_seen = '0;
			reads_done = '0;
			answers_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					flag_mismatch($sformatf("result beat with none expected (slot %0d)",
						out_data.slot));
				end else begin
					want = answers_due.pop_front();
					if (out_data.slot !== want.slot)
						flag_mismatch($sformatf("slot: got %0d, expected %0d",
							out_data.slot, want.slot));
					if (out_data.hit !== want.hit)
						flag_mismatch($sformatf("hit: got %0b, expected %0b",
							out_data.hit, want.hit));
					if (out_data.no_victim !== want.no_victim)
						flag_mismatch($sformatf("no_victim: got %0b, expected %0b",
							out_data.no_victim, want.no_victim));
					if (out_data.hit_count !== want.hit_count)
						flag_mismatch($sformatf("hit_count: got %0d, expected %0d",
							out_data.hit_count, want.hit_count));
					if (out_data.read_count !== want.read_count)
						flag_mismatch($sformatf("read_count: got %0d, expected %0d",
							out_data.read_count, want.read_count));
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(predict_slot_answer(in_data));
		end
		answers_pending <= answers_due.size();
	end

endmodule

// File: tb/tb_clock_sweep_buffer_replacement_core.sv
module tb_clock_sweep_buffer_replacement_core import cswr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS    = 16;
	localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 32;
	localparam int ITEM_TARGET  = 1550;
	localparam int HOT_HITS     = 270;
	localparam int HOT_START    = 600;
	localparam int POOL_SIZE    = 24;

	typedef enum logic [1:0] {
		READY_STEADY,
		READY_COIN,
		READY_SPARSE
	} ready_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	cswr_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	cswr_out_t out_data;
	int        mismatch_count;
	int        answers_pending;

	int beats_sent = 0;
	int burst_left = 0;

	// Working set of page tags, so requests hit often
	logic [OBJ_W-1:0]  pool_obj  [POOL_SIZE];
	logic [PAGE_W-1:0] pool_page [POOL_SIZE];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	clock_sweep_buffer_replacement_core #(
		.NUM_SLOTS(NUM_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	cswr_result_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) slot_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatch_count(mismatch_count),
		.answers_pending(answers_pending)
	);

	function automatic cswr_in_t page_request(input logic [OBJ_W-1:0] obj,
			input logic [PAGE_W-1:0] page);
		cswr_in_t beat;
		beat.opcode = OP_REQUEST;
		beat.object_id = obj;
		beat.page_no = page;
		beat.release_slot = SLOT_W'($urandom);
		return beat;
	endfunction

	function automatic cswr_in_t slot_release(input logic [SLOT_W-1:0] slot);
		cswr_in_t beat;
		beat.opcode = OP_RELEASE;
		beat.object_id = $urandom;
		beat.page_no = PAGE_W'($urandom);
		beat.release_slot = slot;
		return beat;
	endfunction

	// Hold one beat until accepted; at the end of a burst, maybe idle a while
	task automatic send_beat(input cswr_in_t beat);
		int gap;
		in_data <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending until every owed answer has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_pending != 0)
			@(posedge clk);
	endtask

	task automatic refresh_pool();
		for (int k = 0; k < POOL_SIZE; k++) begin
			case ($urandom_range(0, 5))
				0: pool_obj[k] = '1;
				1: pool_obj[k] = '0;
				default: pool_obj[k] = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: pool_page[k] = '1;
				1: pool_page[k] = '0;
				default: pool_page[k] = PAGE_W'($urandom);
			endcase
		end
	endtask

	task automatic send_random_beat();
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		idx = $urandom_range(0, POOL_SIZE - 1);
		if (pick < 40)
			send_beat(slot_release(SLOT_W'($urandom)));
		else if (pick < 80)
			send_beat(page_request(pool_obj[idx], pool_page[idx]));
		else
			send_beat(page_request($urandom, PAGE_W'($urandom)));
	endtask

	// Receiver: stall on a pattern (steady, coin toss or sparse) that changes from span to span
	initial begin : result_sink
		ready_mode_t mode;
		int          span;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 2));
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					READY_STEADY: out_ready <= 1'b1;
					READY_COIN: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		#(20_000_000);
		$display("tb_clock_sweep_buffer_replacement_core: errors");
		$finish;
	end

	initial begin : stimulus
		int               round;
		int               kind;
		int               base;
		int               run;
		bit               hot_done;
		logic [OBJ_W-1:0]  hot_obj;
		logic [PAGE_W-1:0] hot_page;
		round = 0;
		hot_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty slots never hit, even on an all-zero tag
		send_beat(page_request('0, '0));
		send_beat(page_request('1, '1));
		send_beat(page_request('0, '0));
		// release of an empty, unpinned slot
		send_beat(slot_release(SLOT_W'(NUM_SLOTS - 1)));
		// fill and pin every slot
		send_beat(page_request('1, '0));
		send_beat(page_request('0, '1));
		for (int k = 0; k < NUM_SLOTS - 4; k++)
			send_beat(page_request(32'h5A00_0000 + k, PAGE_W'(k + 1)));
		// every slot pinned: no victim
		send_beat(page_request(32'h1234_5678, PAGE_W'(7)));
		// unpin slot 0; the hand wraps and ages it down to zero before taking it
		send_beat(slot_release('0));
		send_beat(page_request(32'h1234_5678, PAGE_W'(7)));
		// the evicted page misses again, with every slot pinned
		send_beat(page_request('0, '0));
		send_beat(slot_release(SLOT_W'(3)));
		wait_drained();

		refresh_pool();
		while (beats_sent < ITEM_TARGET) begin
			round++;
			if (round % 200 == 0)
				refresh_pool();
			kind = $urandom_range(0, 99);
			if (!hot_done && beats_sent >= HOT_START) begin
				// unpin everything, then hammer one page past usage saturation
				hot_done = 1'b1;
				for (int k = 0; k < NUM_SLOTS; k++)
					send_beat(slot_release(SLOT_W'(k)));
				hot_obj = $urandom;
				hot_page = PAGE_W'($urandom);
				repeat (HOT_HITS)
					send_beat(page_request(hot_obj, hot_page));
			end else if (kind < 5) begin
				// unpin a run of slots from a random start
				base = $urandom_range(0, NUM_SLOTS - 1);
				run = $urandom_range(4, NUM_SLOTS);
				for (int k = 0; k < run; k++)
					send_beat(slot_release(SLOT_W'(base + k)));
			end else if (kind < 7) begin
				wait_drained();
			end else begin
				send_random_beat();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_pending == 0)
			$display("tb_clock_sweep_buffer_replacement_core: clean");
		else
			$display("tb_clock_sweep_buffer_replacement_core: errors");
		$finish;
	end

endmodule
